// ===== sv/ffa_pkg.sv =====
// Shared types and constants for the frame to format assembler.
// No dependencies; used by ffa_outq, frame_to_format_assembler and tb_top.
package ffa_pkg;

	localparam int MAX_FRAMES_DEF = 64;
	localparam int FC_W     = 8;
	localparam int FMT_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int SLOT_W   = 7;
	localparam int MISS_W   = 32;
	localparam int QDEPTH   = 4;

	typedef enum logic [2:0] {
		KIND_STORED   = 3'd0,
		KIND_COMPLETE = 3'd1,
		KIND_BREAK    = 3'd2,
		KIND_NOSTART  = 3'd3,
		KIND_TOOLONG  = 3'd4,
		KIND_END      = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [SLOT_W-1:0]    slot;
		logic [HANDLE_W-1:0]  handle;
		logic [SLOT_W-1:0]    frames;
		logic [FMT_W-1:0]     fmt;
		logic                 resynced;
		logic [MISS_W-1:0]    miss;
		logic                 last;
	} res_t;

	// Up to two results leave one item per cycle while the result queue has room
	typedef struct packed {
		logic push0;
		logic push1;
		res_t res0;
		res_t res1;
	} push_t;

endpackage

// ===== sv/frame_to_format_assembler.sv =====
// Top level of the frame to format assembler: input register, assembly state
// and decision logic. Depends on ffa_pkg and ffa_outq.
//
//  channel | handshake            | carries
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | one frame header item
//  cfg     | cfg_valid / cfg_ready| check_counters bit (cfg_data)
//  out     | out_valid / out_ready| one result item, last marks an item's final
//
// An item is accepted every cycle while the result queue has room for two;
// it is decided in the input stage, which holds it until the queue has room,
// and its results then enter the queue. The output port drains one result
// per cycle while out_ready is high. Reset puts the block in hunting with an
// empty queue; a stalled output fills the four-entry queue until it lacks
// room for two and then holds in_ready low.
module frame_to_format_assembler #(
	parameter int MAX_FRAMES = ffa_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          start_of_format,
	input  logic [ffa_pkg::FC_W-1:0]      frame_counter,
	input  logic [ffa_pkg::FMT_W-1:0]     format_number,
	input  logic [ffa_pkg::HANDLE_W-1:0]  payload_handle,
	input  logic                          end_of_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    kind,
	output logic [ffa_pkg::SLOT_W-1:0]    slot,
	output logic [ffa_pkg::HANDLE_W-1:0]  handle_out,
	output logic [ffa_pkg::SLOT_W-1:0]    frames_in_format,
	output logic [ffa_pkg::FMT_W-1:0]     expected_format,
	output logic                          resynced,
	output logic [ffa_pkg::MISS_W-1:0]    miss_total,
	output logic                          last
);

	localparam int TW = ffa_pkg::SLOT_W + 1;

	// Input stage
	logic                          v_s1;
	logic                          sof_s1, eod_s1;
	logic [ffa_pkg::FC_W-1:0]      fc_s1;
	logic [ffa_pkg::FMT_W-1:0]     fn_s1;
	logic [ffa_pkg::HANDLE_W-1:0]  hd_s1;

	// Assembly state
	logic                          check_q;
	logic                          asm_q, asm_d;
	logic [ffa_pkg::FC_W-1:0]      nfc_q, nfc_d;
	logic [ffa_pkg::FMT_W-1:0]     fuw_q, fuw_d;
	logic [ffa_pkg::SLOT_W-1:0]    ft_q, ft_d;
	logic                          mu_q, mu_d;
	logic [ffa_pkg::MISS_W-1:0]    miss_q, miss_d;

	logic            room, advance;
	logic [TW-1:0]   ft_next;
	logic            fc_ok, fn_ok;
	ffa_pkg::push_t  push;
	ffa_pkg::res_t   head;

	assign advance   = v_s1 && room;
	assign in_ready  = !v_s1 || room;
	assign cfg_ready = 1'b1;

	// Capture an accepted item; hold it until the queue takes its results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sof_s1 <= start_of_format;
			eod_s1 <= end_of_data;
			fc_s1  <= frame_counter;
			fn_s1  <= format_number;
			hd_s1  <= payload_handle;
		end
	end

	assign ft_next = TW'(ft_q) + TW'(1);
	assign fc_ok   = (fc_s1 == nfc_q);
	assign fn_ok   = (fn_s1 == fuw_q);

	// Decide the results and next state of the item in the input stage
	always_comb begin
		asm_d  = asm_q;
		nfc_d  = nfc_q;
		fuw_d  = fuw_q;
		ft_d   = ft_q;
		mu_d   = mu_q;
		miss_d = miss_q;
		push   = '0;
		push.res0.kind = ffa_pkg::KIND_STORED;
		push.res1.kind = ffa_pkg::KIND_STORED;
		push.res0.fmt  = fuw_q;
		push.res1.fmt  = fuw_q;

		if (eod_s1) begin
			push.push0     = 1'b1;
			push.res0.kind = ffa_pkg::KIND_END;
			asm_d = 1'b0;
			ft_d  = '0;
			mu_d  = 1'b1;
		end else if (!asm_q) begin
			// Hunt: take a start frame, or report a missing start once
			nfc_d = fc_s1;
			fuw_d = fn_s1;
			if (sof_s1) begin
				push.push0         = 1'b1;
				push.res0.handle   = hd_s1;
				push.res0.fmt      = fn_s1;
				push.res0.resynced = !mu_q;
				mu_d  = 1'b1;
				nfc_d = fc_s1 + ffa_pkg::FC_W'(1);
				ft_d  = ffa_pkg::SLOT_W'(1);
				asm_d = 1'b1;
			end else if (mu_q) begin
				push.push0     = 1'b1;
				push.res0.kind = ffa_pkg::KIND_NOSTART;
				push.res0.fmt  = fn_s1;
				mu_d = 1'b0;
			end
		end else if (sof_s1) begin
			// Start frame closes the format, then opens the next one
			push.push0 = 1'b1;
			push.push1 = 1'b1;
			if (check_q && !fc_ok) begin
				if (miss_q != '1) miss_d = miss_q + ffa_pkg::MISS_W'(1);
				push.res0.kind     = ffa_pkg::KIND_BREAK;
				push.res1.resynced = !mu_q;
			end else begin
				push.res0.kind     = ffa_pkg::KIND_COMPLETE;
				push.res0.frames   = ft_q;
				push.res1.resynced = 1'b0;
			end
			push.res1.handle = hd_s1;
			push.res1.fmt    = fn_s1;
			mu_d  = 1'b1;
			nfc_d = fc_s1 + ffa_pkg::FC_W'(1);
			fuw_d = fn_s1;
			ft_d  = ffa_pkg::SLOT_W'(1);
			asm_d = 1'b1;
		end else if (!check_q || (fc_ok && fn_ok)) begin
			// Store the frame in its slot; end the format if it grows too long
			push.push0        = 1'b1;
			push.res0.slot    = ft_q;
			push.res0.handle  = hd_s1;
			nfc_d = nfc_q + ffa_pkg::FC_W'(1);
			ft_d  = ft_next[ffa_pkg::SLOT_W-1:0];
			if (ft_next > TW'(MAX_FRAMES)) begin
				push.push1        = 1'b1;
				push.res1.kind    = ffa_pkg::KIND_TOOLONG;
				push.res1.frames  = ft_next[ffa_pkg::SLOT_W-1:0];
				asm_d = 1'b0;
				ft_d  = '0;
				mu_d  = 1'b1;
			end
		end else begin
			// Broken sequence: count a miss, then hunt on the same frame
			if (miss_q != '1) miss_d = miss_q + ffa_pkg::MISS_W'(1);
			push.push0     = 1'b1;
			push.res0.kind = ffa_pkg::KIND_BREAK;
			asm_d = 1'b0;
			ft_d  = '0;
			nfc_d = fc_s1;
			fuw_d = fn_s1;
			if (mu_q) begin
				push.push1     = 1'b1;
				push.res1.kind = ffa_pkg::KIND_NOSTART;
				push.res1.fmt  = fn_s1;
				mu_d = 1'b0;
			end
		end

		push.res0.miss = miss_d;
		push.res1.miss = miss_d;
		push.res0.last = !push.push1;
		push.res1.last = 1'b1;

		if (!advance) begin
			push.push0 = 1'b0;
			push.push1 = 1'b0;
		end
	end

	// Update state when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= 1'b1;
			asm_q   <= 1'b0;
			nfc_q   <= '0;
			fuw_q   <= '0;
			ft_q    <= '0;
			mu_q    <= 1'b1;
			miss_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) check_q <= cfg_data;
			if (advance) begin
				asm_q  <= asm_d;
				nfc_q  <= nfc_d;
				fuw_q  <= fuw_d;
				ft_q   <= ft_d;
				mu_q   <= mu_d;
				miss_q <= miss_d;
			end
		end
	end

	ffa_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind             = head.kind;
	assign slot             = head.slot;
	assign handle_out       = head.handle;
	assign frames_in_format = head.frames;
	assign expected_format  = head.fmt;
	assign resynced         = head.resynced;
	assign miss_total       = head.miss;
	assign last             = head.last;

endmodule

// ===== sv/ffa_outq.sv =====
// Result queue of the frame to format assembler: takes up to two result items
// per cycle and hands out one while out_ready is high. Depends on ffa_pkg.
module ffa_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  ffa_pkg::push_t  push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output ffa_pkg::res_t   head
);

	localparam int AW = $clog2(ffa_pkg::QDEPTH);
	localparam int CW = $clog2(ffa_pkg::QDEPTH + 1);

	ffa_pkg::res_t mem_q [ffa_pkg::QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [CW-1:0] n_push;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign head      = mem_q[rd_q];
	assign room      = (count_q <= CW'(ffa_pkg::QDEPTH - 2));
	assign n_push    = CW'(push.push0) + CW'(push.push1);

	// Store pushed items in order
	always_ff @(posedge clk) begin
		if (push.push0) mem_q[wr_q] <= push.res0;
		if (push.push1) mem_q[wr_q + AW'(1)] <= push.res1;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + AW'(n_push);
			if (pop) rd_q <= rd_q + AW'(1);
			count_q <= count_q + n_push - CW'(pop);
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frame_to_format_assembler: directed frame table,
// then random format sequences under both checking modes, scored by a predictor.
// Depends on ffa_pkg and the assembler RTL.
module tb_top;

	localparam int MAX_FR     = ffa_pkg::MAX_FRAMES_DEF;
	localparam int PHASE_LEN  = 290;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		logic                         sof;
		logic [ffa_pkg::FC_W-1:0]     fc;
		logic [ffa_pkg::FMT_W-1:0]    fn;
		logic [ffa_pkg::HANDLE_W-1:0] h;
		logic                         eod;
		logic                         typed;
		ffa_pkg::res_t                want;
	} dir_row_t;

	// Rows with typed results are read straight off the behavior; the rest go
	// through the predictor.
	localparam dir_row_t DIR_ROWS [16] = '{
		'{1'b0, 8'd0, 32'd0, 16'd0, 1'b1, 1'b1,
			'{ffa_pkg::KIND_END, 7'd0, 16'd0, 7'd0, 32'd0, 1'b0, 32'd0, 1'b1}},
		'{1'b0, 8'd5, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1,
			'{ffa_pkg::KIND_NOSTART, 7'd0, 16'd0, 7'd0, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b1}},
		'{1'b0, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0, '0},
		'{1'b1, 8'd255, 32'd0, 16'hFFFF, 1'b0, 1'b1,
			'{ffa_pkg::KIND_STORED, 7'd0, 16'hFFFF, 7'd0, 32'd0, 1'b1, 32'd0, 1'b1}},
		'{1'b0, 8'd0, 32'd0, 16'd0, 1'b0, 1'b0, '0},
		'{1'b0, 8'd1, 32'd0, 16'h1234, 1'b0, 1'b0, '0},
		'{1'b0, 8'd2, 32'd1, 16'h00FF, 1'b0, 1'b0, '0},
		'{1'b1, 8'd10, 32'd7, 16'hFF00, 1'b0, 1'b0, '0},
		'{1'b0, 8'd12, 32'd7, 16'h5555, 1'b0, 1'b0, '0},
		'{1'b1, 8'd20, 32'd8, 16'hAAAA, 1'b0, 1'b0, '0},
		'{1'b0, 8'd21, 32'd8, 16'h0F0F, 1'b0, 1'b0, '0},
		'{1'b1, 8'd22, 32'd9, 16'hF0F0, 1'b0, 1'b0, '0},
		'{1'b1, 8'd30, 32'd10, 16'h3C3C, 1'b0, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, 16'd0, 1'b1, 1'b0, '0},
		'{1'b1, 8'hA5, 32'h8000_0000, 16'hC3C3, 1'b1, 1'b0, '0},
		'{1'b1, 8'd7, 32'h7FFF_FFFF, 16'h0001, 1'b0, 1'b0, '0}
	};

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic                         start_of_format;
	logic [ffa_pkg::FC_W-1:0]     frame_counter;
	logic [ffa_pkg::FMT_W-1:0]    format_number;
	logic [ffa_pkg::HANDLE_W-1:0] payload_handle;
	logic                         end_of_data;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic                         cfg_data;
	logic                         out_valid;
	logic                         out_ready;
	logic [2:0]                   kind;
	logic [ffa_pkg::SLOT_W-1:0]   slot;
	logic [ffa_pkg::HANDLE_W-1:0] handle_out;
	logic [ffa_pkg::SLOT_W-1:0]   frames_in_format;
	logic [ffa_pkg::FMT_W-1:0]    expected_format;
	logic                         resynced;
	logic [ffa_pkg::MISS_W-1:0]   miss_total;
	logic                         last;

	frame_to_format_assembler #(
		.MAX_FRAMES(MAX_FR)
	) u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.start_of_format  (start_of_format),
		.frame_counter    (frame_counter),
		.format_number    (format_number),
		.payload_handle   (payload_handle),
		.end_of_data      (end_of_data),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.kind             (kind),
		.slot             (slot),
		.handle_out       (handle_out),
		.frames_in_format (frames_in_format),
		.expected_format  (expected_format),
		.resynced         (resynced),
		.miss_total       (miss_total),
		.last             (last)
	);

	// Clock: 12 ns period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predictor state
	logic                       pr_check;
	logic                       pr_assembling;
	logic [ffa_pkg::FC_W-1:0]   pr_next_fc;
	logic [ffa_pkg::FMT_W-1:0]  pr_fmt;
	int                         pr_taken;
	logic                       pr_miss_open;
	logic [ffa_pkg::MISS_W-1:0] pr_miss_cnt;

	ffa_pkg::res_t frame_results [$];
	ffa_pkg::res_t pending_results [$];

	int errors;
	int items_sent;
	int results_seen;
	int kinds_seen [6];
	int in_idle_pct;
	int out_idle_pct;
	bit quiet;

	// Random format generator state
	logic [ffa_pkg::FC_W-1:0]  gen_fc;
	logic [ffa_pkg::FMT_W-1:0] gen_fn;
	int                        gen_left;
	bit                        gen_noisy;

	function automatic ffa_pkg::res_t make_result(ffa_pkg::kind_t k, int s,
			logic [ffa_pkg::HANDLE_W-1:0] h, int frames,
			logic [ffa_pkg::FMT_W-1:0] fmt, logic rs);
		ffa_pkg::res_t r;
		r.kind     = k;
		r.slot     = s[ffa_pkg::SLOT_W-1:0];
		r.handle   = h;
		r.frames   = frames[ffa_pkg::SLOT_W-1:0];
		r.fmt      = fmt;
		r.resynced = rs;
		r.miss     = pr_miss_cnt;
		r.last     = 1'b0;
		return r;
	endfunction

	task automatic count_break();
		if (pr_miss_cnt != '1)
			pr_miss_cnt = pr_miss_cnt + 1'b1;
	endtask

	// Hunt: open a format on a start frame, else report a missing start once
	task automatic hunt_frame(logic sof, logic [ffa_pkg::FC_W-1:0] fc,
			logic [ffa_pkg::FMT_W-1:0] fn, logic [ffa_pkg::HANDLE_W-1:0] h);
		pr_next_fc = fc;
		pr_fmt     = fn;
		if (sof) begin
			frame_results.push_back(make_result(ffa_pkg::KIND_STORED, 0, h, 0, pr_fmt,
				!pr_miss_open));
			pr_miss_open  = 1'b1;
			pr_next_fc    = fc + 1'b1;
			pr_taken      = 1;
			pr_assembling = 1'b1;
		end else if (pr_miss_open) begin
			pr_miss_open = 1'b0;
			frame_results.push_back(make_result(ffa_pkg::KIND_NOSTART, 0, '0, 0, fn, 1'b0));
		end
	endtask

	// Work out the results of one frame header into frame_results
	task automatic predict_frame(logic sof, logic [ffa_pkg::FC_W-1:0] fc,
			logic [ffa_pkg::FMT_W-1:0] fn, logic [ffa_pkg::HANDLE_W-1:0] h, logic eod);
		ffa_pkg::res_t tail;
		frame_results.delete();
		if (eod) begin
			frame_results.push_back(make_result(ffa_pkg::KIND_END, 0, '0, 0, pr_fmt, 1'b0));
			pr_assembling = 1'b0;
			pr_taken      = 0;
			pr_miss_open  = 1'b1;
		end else if (!pr_assembling) begin
			hunt_frame(sof, fc, fn, h);
		end else if (sof) begin
			if (pr_check && fc != pr_next_fc) begin
				count_break();
				frame_results.push_back(make_result(ffa_pkg::KIND_BREAK, 0, '0, 0, pr_fmt,
					1'b0));
			end else begin
				frame_results.push_back(make_result(ffa_pkg::KIND_COMPLETE, 0, '0, pr_taken,
					pr_fmt, 1'b0));
				pr_miss_open = 1'b1;
			end
			pr_assembling = 1'b0;
			pr_taken      = 0;
			hunt_frame(sof, fc, fn, h);
		end else if (!pr_check || (fc == pr_next_fc && fn == pr_fmt)) begin
			frame_results.push_back(make_result(ffa_pkg::KIND_STORED, pr_taken, h, 0, pr_fmt,
				1'b0));
			pr_next_fc = pr_next_fc + 1'b1;
			pr_taken++;
			if (pr_taken > MAX_FR) begin
				frame_results.push_back(make_result(ffa_pkg::KIND_TOOLONG, 0, '0, pr_taken,
					pr_fmt, 1'b0));
				pr_assembling = 1'b0;
				pr_taken      = 0;
				pr_miss_open  = 1'b1;
			end
		end else begin
			count_break();
			frame_results.push_back(make_result(ffa_pkg::KIND_BREAK, 0, '0, 0, pr_fmt, 1'b0));
			pr_assembling = 1'b0;
			pr_taken      = 0;
			hunt_frame(sof, fc, fn, h);
		end
		// Mark the final result of this item
		if (frame_results.size() > 0) begin
			tail      = frame_results.pop_back();
			tail.last = 1'b1;
			frame_results.push_back(tail);
		end
	endtask

	// Send one frame item, optionally after an idle burst; predict on acceptance
	task automatic send_frame(logic sof, logic [ffa_pkg::FC_W-1:0] fc,
			logic [ffa_pkg::FMT_W-1:0] fn, logic [ffa_pkg::HANDLE_W-1:0] h, logic eod,
			logic typed, ffa_pkg::res_t want);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < in_idle_pct)
			gap = $urandom_range(1, 15);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid        <= 1'b1;
		start_of_format <= sof;
		frame_counter   <= fc;
		format_number   <= fn;
		payload_handle  <= h;
		end_of_data     <= eod;
		do @(posedge clk); while (!in_ready);
		predict_frame(sof, fc, fn, h, eod);
		if (typed)
			pending_results.push_back(want);
		else
			foreach (frame_results[i])
				pending_results.push_back(frame_results[i]);
		items_sent++;
	endtask

	// Write the checking mode once everything in flight has drained
	task automatic write_check(logic v);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		pr_check = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Build the next random frame: mostly well-formed formats, some breaks and noise
	task automatic next_random(output logic sof, output logic [ffa_pkg::FC_W-1:0] fc,
			output logic [ffa_pkg::FMT_W-1:0] fn, output logic [ffa_pkg::HANDLE_W-1:0] h,
			output logic eod);
		int r;
		r   = $urandom_range(0, 99);
		sof = 1'b0;
		fc  = gen_fc;
		fn  = gen_fn;
		h   = 16'($urandom());
		eod = 1'b0;
		if (gen_noisy && r < 3) begin
			// end of scan region, other fields random
			sof      = 1'($urandom_range(0, 1));
			fc       = 8'($urandom());
			fn       = $urandom();
			eod      = 1'b1;
			gen_left = 0;
		end else if (gen_noisy && r < 7) begin
			// noise frame
			sof = 1'($urandom_range(0, 1));
			fc  = 8'($urandom());
			fn  = $urandom();
		end else if (gen_left == 0) begin
			// open a new format
			sof = 1'b1;
			if ($urandom_range(0, 3) == 0)
				fc = 8'($urandom());
			if ($urandom_range(0, 7) == 0)
				fn = $urandom();
			else
				fn = gen_fn + 1'b1;
			gen_fc    = fc + 1'b1;
			gen_fn    = fn;
			gen_noisy = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) == 0)
				gen_left = $urandom_range(60, 70);
			else
				gen_left = $urandom_range(0, 8);
		end else if (gen_noisy && r < 14) begin
			// broken continuation: bad counter or changed format
			if ($urandom_range(0, 1) == 0)
				fc = gen_fc + 8'($urandom_range(1, 255));
			else
				fn = gen_fn ^ (32'($urandom()) | 32'h1);
			gen_left = 0;
		end else begin
			gen_fc = gen_fc + 1'b1;
			gen_left--;
		end
	endtask

	// Receiver: stall in random bursts
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
				stall_left = $urandom_range(1, 15) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Score each accepted result against the oldest expectation
	always @(posedge clk) begin
		ffa_pkg::res_t want;
		bit            ok;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (kind < 3'd6)
				kinds_seen[kind]++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, kind %0d slot %0d", $time, kind, slot);
				errors++;
			end else begin
				want = pending_results.pop_front();
				ok = 1'b1;
				ok &= field_ok("kind", 32'(want.kind), 32'(kind));
				ok &= field_ok("slot", 32'(want.slot), 32'(slot));
				ok &= field_ok("handle_out", 32'(want.handle), 32'(handle_out));
				ok &= field_ok("frames_in_format", 32'(want.frames), 32'(frames_in_format));
				ok &= field_ok("expected_format", want.fmt, expected_format);
				ok &= field_ok("resynced", 32'(want.resynced), 32'(resynced));
				ok &= field_ok("miss_total", want.miss, miss_total);
				ok &= field_ok("last", 32'(want.last), 32'(last));
				if (!ok)
					errors++;
			end
		end
	end

	// Watchdog: end the run after too long without any handshake
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no handshake for %0d cycles, %0d results outstanding",
			$time, IDLE_LIMIT, pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		logic                         sof;
		logic [ffa_pkg::FC_W-1:0]     fc;
		logic [ffa_pkg::FMT_W-1:0]    fn;
		logic [ffa_pkg::HANDLE_W-1:0] h;
		logic                         eod;
		logic                         cfg_plan [4];
		// Hold all inputs at known values through reset
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		start_of_format = 1'b0;
		frame_counter   = '0;
		format_number   = '0;
		payload_handle  = '0;
		end_of_data     = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = 1'b0;
		errors          = 0;
		items_sent      = 0;
		results_seen    = 0;
		foreach (kinds_seen[k])
			kinds_seen[k] = 0;
		in_idle_pct     = 25;
		out_idle_pct    = 25;
		quiet           = 1'b0;
		pr_check        = 1'b1;
		pr_assembling   = 1'b0;
		pr_next_fc      = '0;
		pr_fmt          = '0;
		pr_taken        = 0;
		pr_miss_open    = 1'b1;
		pr_miss_cnt     = '0;
		gen_fc          = '0;
		gen_fn          = '0;
		gen_left        = 0;
		gen_noisy       = 1'b1;
		cfg_plan        = '{1'b0, 1'b1, 1'b0, 1'b1};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table with checking at its reset value
		foreach (DIR_ROWS[i])
			send_frame(DIR_ROWS[i].sof, DIR_ROWS[i].fc, DIR_ROWS[i].fn, DIR_ROWS[i].h,
				DIR_ROWS[i].eod, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		@(negedge clk);
		in_valid <= 1'b0;

		// Random formats in four phases alternating the checking mode; last phase runs without idling
		for (int p = 0; p < 4; p++) begin
			write_check(cfg_plan[p]);
			quiet = (p == 3);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (n % 50 == 0) begin
					in_idle_pct  = 30 * $urandom_range(0, 2);
					out_idle_pct = 30 * $urandom_range(0, 2);
				end
				next_random(sof, fc, fn, h, eod);
				send_frame(sof, fc, fn, h, eod, 1'b0, '0);
			end
			@(negedge clk);
			in_valid <= 1'b0;
		end

		// Drain, then leave room for anything stray
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d frames, %0d results: stored %0d, complete %0d, break %0d,",
			items_sent, results_seen, kinds_seen[ffa_pkg::KIND_STORED],
			kinds_seen[ffa_pkg::KIND_COMPLETE], kinds_seen[ffa_pkg::KIND_BREAK]);
		$display("  start missing %0d, too long %0d, end %0d; checking on and off",
			kinds_seen[ffa_pkg::KIND_NOSTART], kinds_seen[ffa_pkg::KIND_TOOLONG],
			kinds_seen[ffa_pkg::KIND_END]);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
